// ===== sv/siem_pkg.sv =====
// ----------------------------------------------------------------------------
// siem_pkg
// Shared constants, selector codes and controller/datapath interface types
// for the sparse index expand/merge block.
// ----------------------------------------------------------------------------
`default_nettype none

package siem_pkg;

  localparam int MAX_INSERTED_DEF = 32;
  localparam int INDEX_BITS_DEF   = 20;
  localparam int VALUE_BITS       = 64;
  localparam int FUNC_BITS        = 2;

  localparam logic [FUNC_BITS-1:0] FUNC_LOAD   = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_SOURCE = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_FINISH = 2'd2;

  typedef struct packed {
    logic take_in;
    logic load;
    logic pass_inc;
    logic pass_clr;
    logic emit_ins;
    logic emit_src;
    logic out_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mode;
    logic pending;
    logic hit;
    logic rd_ok;
    logic out_free;
    logic last_pending;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/siem_ram.sv =====
// ----------------------------------------------------------------------------
// siem_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module siem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_BITS-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]     wr_data,
  input  wire logic [ADDR_BITS-1:0] rd_addr,
  output logic      [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

// ===== sv/siem_dp.sv =====
// ----------------------------------------------------------------------------
// siem_dp
// Datapath: inserted-entry store, list and walk counters, input holding
// registers, shifted-index compare and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module siem_dp #(
  parameter int MAX_INSERTED = siem_pkg::MAX_INSERTED_DEF,
  parameter int INDEX_BITS   = siem_pkg::INDEX_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_write,
  input  wire logic                            cfg_data,
  input  wire logic [INDEX_BITS-1:0]           in_index,
  input  wire logic [siem_pkg::VALUE_BITS-1:0] in_value,
  input  wire logic                            out_stall,
  output logic                                 out_valid,
  output logic      [INDEX_BITS-1:0]           out_index,
  output logic      [siem_pkg::VALUE_BITS-1:0] out_value,
  output logic                                 out_last,
  input  wire siem_pkg::ctrl_cmd_t             cmd,
  output siem_pkg::dp_stat_t                   stat
);

  localparam int CNT_BITS  = $clog2(MAX_INSERTED + 1);
  localparam int ADDR_BITS = (MAX_INSERTED > 1) ? $clog2(MAX_INSERTED) : 1;
  localparam int SUM_BITS  = ((INDEX_BITS > CNT_BITS) ? INDEX_BITS : CNT_BITS) + 1;
  localparam int WORD_BITS = INDEX_BITS + siem_pkg::VALUE_BITS;

  logic                            mode_r;
  logic [CNT_BITS-1:0]             ins_cnt_r, ins_cnt_nxt;
  logic [CNT_BITS-1:0]             pass_cnt_r, pass_cnt_nxt;
  logic                            rd_ok_r, rd_ok_nxt;
  logic [INDEX_BITS-1:0]           idx_r;
  logic [siem_pkg::VALUE_BITS-1:0] val_r;
  logic                            out_valid_r, out_valid_nxt;
  logic [INDEX_BITS-1:0]           out_index_r, out_index_nxt;
  logic [siem_pkg::VALUE_BITS-1:0] out_value_r, out_value_nxt;
  logic                            out_last_r, out_last_nxt;

  logic                            wr_en;
  logic [ADDR_BITS-1:0]            wr_addr;
  logic [ADDR_BITS-1:0]            rd_addr;
  logic [WORD_BITS-1:0]            rd_data;
  logic [INDEX_BITS-1:0]           ins_pos;
  logic [siem_pkg::VALUE_BITS-1:0] ins_val;
  logic [SUM_BITS-1:0]             sum;
  logic [CNT_BITS-1:0]             pass_plus;
  logic                            out_free;

  assign wr_en   = cmd.load && (ins_cnt_r < CNT_BITS'(MAX_INSERTED));
  assign wr_addr = ins_cnt_r[ADDR_BITS-1:0];
  assign rd_addr = pass_cnt_r[ADDR_BITS-1:0];

  siem_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAX_INSERTED)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({in_index, in_value}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign ins_pos   = rd_data[WORD_BITS-1 -: INDEX_BITS];
  assign ins_val   = rd_data[siem_pkg::VALUE_BITS-1:0];
  assign sum       = SUM_BITS'(idx_r) + SUM_BITS'(pass_cnt_r);
  assign pass_plus = pass_cnt_r + CNT_BITS'(1);
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    stat.mode         = mode_r;
    stat.pending      = pass_cnt_r < ins_cnt_r;
    stat.hit          = SUM_BITS'(ins_pos) <= sum;
    stat.rd_ok        = rd_ok_r;
    stat.out_free     = out_free;
    stat.last_pending = pass_plus == ins_cnt_r;
  end

  always_comb begin
    ins_cnt_nxt  = wr_en ? ins_cnt_r + CNT_BITS'(1) : ins_cnt_r;
    pass_cnt_nxt = pass_cnt_r;
    if (cmd.pass_clr) begin
      pass_cnt_nxt = '0;
    end else if (cmd.pass_inc) begin
      pass_cnt_nxt = pass_plus;
    end
    // read data is good when its read used the current address and no write hit that address
    rd_ok_nxt = !cmd.pass_inc && !cmd.pass_clr && !(wr_en && (wr_addr == rd_addr));
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_index_nxt = out_index_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    if (cmd.emit_ins) begin
      out_valid_nxt = 1'b1;
      out_index_nxt = ins_pos;
      out_value_nxt = ins_val;
      out_last_nxt  = cmd.out_last;
    end else if (cmd.emit_src) begin
      out_valid_nxt = 1'b1;
      out_index_nxt = sum[INDEX_BITS-1:0];
      out_value_nxt = val_r;
      out_last_nxt  = cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b1;
      ins_cnt_r   <= '0;
      pass_cnt_r  <= '0;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write) begin
        mode_r <= cfg_data;
      end
      ins_cnt_r   <= ins_cnt_nxt;
      pass_cnt_r  <= pass_cnt_nxt;
      rd_ok_r     <= rd_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      idx_r <= in_index;
      val_r <= in_value;
    end
    out_index_r <= out_index_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_index = out_index_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

// ===== sv/siem_ctrl.sv =====
// ----------------------------------------------------------------------------
// siem_ctrl
// Controller: accepts words, walks pending inserted entries for a source
// word or a finish, and sequences emission into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module siem_ctrl (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  input  wire logic [siem_pkg::FUNC_BITS-1:0]     in_func,
  output logic                                    in_stall,
  input  wire siem_pkg::dp_stat_t                 stat,
  output siem_pkg::ctrl_cmd_t                     cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SOURCE,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = state_r != ST_IDLE;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_func)
            siem_pkg::FUNC_LOAD: begin
              cmd.load = 1'b1;
            end
            siem_pkg::FUNC_SOURCE: begin
              cmd.take_in = 1'b1;
              state_nxt   = ST_SOURCE;
            end
            siem_pkg::FUNC_FINISH: begin
              state_nxt = ST_FINISH;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SOURCE: begin
        if (stat.pending && !stat.rd_ok) begin
          state_nxt = ST_SOURCE;
        end else if (stat.pending && stat.hit) begin
          if (!stat.mode) begin
            cmd.pass_inc = 1'b1;
          end else if (stat.out_free) begin
            cmd.emit_ins = 1'b1;
            cmd.pass_inc = 1'b1;
          end
        end else if (stat.out_free) begin
          cmd.emit_src = 1'b1;
          cmd.out_last = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (!stat.mode || !stat.pending) begin
          cmd.pass_clr = 1'b1;
          state_nxt    = ST_IDLE;
        end else if (stat.rd_ok && stat.out_free) begin
          cmd.emit_ins = 1'b1;
          cmd.out_last = stat.last_pending;
          if (stat.last_pending) begin
            cmd.pass_clr = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            cmd.pass_inc = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sparse_index_expand_merge.sv =====
// ----------------------------------------------------------------------------
// sparse_index_expand_merge
// Expands a reduced sparse vector into full index space, merging a loaded
// sorted list of inserted entries.
// ----------------------------------------------------------------------------
// Sequencing: a load word is written to the store at accept while the list has room,
//   else dropped; loads are taken back to back. A source word is held in the input
//   registers and its result is emitted once the output register is free; each inserted
//   entry passed or emitted first waits for a registered read of the store at the walk
//   pointer. in_stall holds off new words until a source or finish walk is done.
// Reset (rst_n, synchronous): counters clear, insert_mode = 1, store not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_index_expand_merge #(
  parameter int MAX_INSERTED = siem_pkg::MAX_INSERTED_DEF,
  parameter int INDEX_BITS   = siem_pkg::INDEX_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_write,
  input  wire logic                            cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [siem_pkg::FUNC_BITS-1:0]  in_func,
  input  wire logic [INDEX_BITS-1:0]           in_index,
  input  wire logic [siem_pkg::VALUE_BITS-1:0] in_value,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [INDEX_BITS-1:0]           out_index,
  output logic      [siem_pkg::VALUE_BITS-1:0] out_value,
  output logic                                 out_last
);

  siem_pkg::ctrl_cmd_t cmd;
  siem_pkg::dp_stat_t  stat;

  siem_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  siem_dp #(
    .MAX_INSERTED (MAX_INSERTED),
    .INDEX_BITS   (INDEX_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_index  (in_index),
    .in_value  (in_value),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_index (out_index),
    .out_value (out_value),
    .out_last  (out_last),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

`default_nettype wire
